### src/rsc_pkg.sv
package rsc_pkg;

    // letter and rotor entry width, fixed by the word format
    localparam int LW = 5;
    // operation field width
    localparam int OPW = 2;
    // rotor select field width
    localparam int SELW = 2;
    // span of the letter field, used for the reduction table
    localparam int LSPAN = 1 << LW;

    // operation codes; code 3 is ignored
    typedef enum logic [OPW-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_DECODE = 2'd2
    } t_op;

    // one rotor entry write
    typedef struct packed {
        logic            en;
        logic [SELW-1:0] sel;
        logic [LW-1:0]   idx;
        logic [LW-1:0]   value;
    } t_rotor_wr;

endpackage

### src/rsc_rotor_bank.sv
module rsc_rotor_bank
    import rsc_pkg::*;
#(
    parameter int ALPHABET_SIZE = 26,
    parameter int ROTOR_COUNT   = 3
) (
    input  logic          i_clk,
    input  t_rotor_wr     i_wr,
    input  logic          i_decode,
    input  logic [LW-1:0] i_letter,
    output logic [LW-1:0] o_letter
);

    localparam int IW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    // rotor entries, one flop word per position
    logic [LW-1:0] r_rotor [ROTOR_COUNT][ALPHABET_SIZE];

    logic [LW-1:0] w_enc;
    logic [LW-1:0] w_dec;

    // entry write, decoded per position
    for (genvar r = 0; r < ROTOR_COUNT; r++) begin : g_rot
        for (genvar e = 0; e < ALPHABET_SIZE; e++) begin : g_ent
            always_ff @(posedge i_clk) begin
                if (i_wr.en && (int'(i_wr.sel) == r) && (int'(i_wr.idx) == e)) begin
                    r_rotor[r][e] <= i_wr.value;
                end
            end
        end
    end

    // forward path: first rotor to last
    always_comb begin
        w_enc = i_letter;
        for (int r = 0; r < ROTOR_COUNT; r++) begin
            w_enc = r_rotor[r][w_enc[IW-1:0]];
        end
    end

    // inverse path: last rotor first, lowest matching position wins
    always_comb begin
        logic [LW-1:0] x_cur;
        logic [LW-1:0] x_nxt;
        logic          found;
        x_cur = i_letter;
        for (int r = ROTOR_COUNT - 1; r >= 0; r--) begin
            found = 1'b0;
            x_nxt = x_cur;
            for (int j = 0; j < ALPHABET_SIZE; j++) begin
                if (!found && (r_rotor[r][j] == x_cur)) begin
                    x_nxt = LW'(j);
                    found = 1'b1;
                end
            end
            x_cur = x_nxt;
        end
        w_dec = x_cur;
    end

    assign o_letter = i_decode ? w_dec : w_enc;

endmodule

### src/rotor_substitution_cipher.sv
// channel   | handshake                 | word
// ----------+---------------------------+---------------------------------------------
// input     | i_in_valid / o_in_ready   | operation, rotor_select, entry_index, letter,
//           |                           | message_start
// output    | o_out_valid / i_out_ready | result_letter
// config    | i_cfg_we (no wait)        | i_cfg_data: start shift
//
// One word per cycle while the result is not stalled. A word taken into the input
// register passes the shift adder and rotor chain, then lands in the result register
// when it advances. Synchronous active-low reset clears the valid flags, the
// running shift and the start shift; rotor entries are undefined until loaded.
// A stalled result holds the input register; load words drain without a result.
module rotor_substitution_cipher
    import rsc_pkg::*;
#(
    parameter int ALPHABET_SIZE = 26,
    parameter int ROTOR_COUNT   = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [OPW-1:0]  i_operation,
    input  logic [SELW-1:0] i_rotor_select,
    input  logic [LW-1:0]   i_entry_index,
    input  logic [LW-1:0]   i_letter,
    input  logic            i_message_start,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [LW-1:0]   o_result_letter,
    input  logic            i_cfg_we,
    input  logic [LW-1:0]   i_cfg_data
);

    localparam logic [LW:0] A6 = (LW + 1)'(ALPHABET_SIZE);

    // input register
    logic            r_in_valid;
    logic [OPW-1:0]  r_op;
    logic [SELW-1:0] r_sel;
    logic [LW-1:0]   r_idx;
    logic [LW-1:0]   r_letter;
    logic            r_msg_start;

    // state and result register
    logic [LW-1:0]   r_shift;
    logic [LW-1:0]   r_start_shift;
    logic            r_out_valid;
    logic [LW-1:0]   r_out_letter;

    logic [LW-1:0]   n_shift;
    logic            n_out_valid;

    logic [LW-1:0]   w_mod_tab [LSPAN];
    logic            w_has_result;
    logic            w_is_load;
    logic            w_is_decode;
    logic            w_advance;
    logic [LW-1:0]   w_shift_cur;
    logic [LW-1:0]   w_letter_m;
    logic [LW:0]     w_sum;
    logic [LW-1:0]   w_rot_in;
    logic [LW-1:0]   w_rot_out;
    logic [LW:0]     w_diff;
    logic [LW-1:0]   w_result;
    t_rotor_wr       w_wr;

    // reduction table for 5-bit values
    for (genvar v = 0; v < LSPAN; v++) begin : g_mod
        assign w_mod_tab[v] = LW'(v % ALPHABET_SIZE);
    end

    // operation decode
    always_comb begin
        w_has_result = 1'b0;
        w_is_load    = 1'b0;
        w_is_decode  = 1'b0;
        unique case (r_op)
            OP_LOAD:   w_is_load = 1'b1;
            OP_ENCODE: w_has_result = 1'b1;
            OP_DECODE: begin
                w_has_result = 1'b1;
                w_is_decode  = 1'b1;
            end
            default: ;
        endcase
    end

    // pipeline flow
    assign w_advance  = r_in_valid && (!w_has_result || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    // shift in effect for this word and letter reduction
    assign w_shift_cur = r_msg_start ? w_mod_tab[r_start_shift] : r_shift;
    assign w_letter_m  = w_mod_tab[r_letter];

    // forward shift ahead of the rotors
    assign w_sum    = {1'b0, w_letter_m} + {1'b0, w_shift_cur};
    assign w_rot_in = w_is_decode ? w_letter_m
                    : ((w_sum >= A6) ? LW'(w_sum - A6) : w_sum[LW-1:0]);

    // rotor entry write
    always_comb begin
        w_wr.en    = w_advance && w_is_load
                     && (int'(r_sel) < ROTOR_COUNT) && (int'(r_idx) < ALPHABET_SIZE);
        w_wr.sel   = r_sel;
        w_wr.idx   = r_idx;
        w_wr.value = w_letter_m;
    end

    rsc_rotor_bank #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .ROTOR_COUNT   (ROTOR_COUNT)
    ) u_bank (
        .i_clk    (i_clk),
        .i_wr     (w_wr),
        .i_decode (w_is_decode),
        .i_letter (w_rot_in),
        .o_letter (w_rot_out)
    );

    // inverse shift after the rotors
    assign w_diff   = {1'b0, w_rot_out} - {1'b0, w_shift_cur};
    assign w_result = !w_is_decode ? w_rot_out
                    : (w_diff[LW] ? LW'(w_diff + A6) : w_diff[LW-1:0]);

    // next running shift and result valid
    always_comb begin
        n_shift = r_shift;
        if (w_advance && w_has_result) begin
            n_shift = (int'(w_shift_cur) == ALPHABET_SIZE - 1) ? '0 : w_shift_cur + 1'b1;
        end
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_advance && w_has_result) begin
            n_out_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_shift       <= '0;
            r_start_shift <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_out_valid <= n_out_valid;
            r_shift     <= n_shift;
            if (i_cfg_we) begin
                r_start_shift <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op        <= i_operation;
            r_sel       <= i_rotor_select;
            r_idx       <= i_entry_index;
            r_letter    <= i_letter;
            r_msg_start <= i_message_start;
        end
        if (w_advance && w_has_result) begin
            r_out_letter <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_letter = r_out_letter;

    // running shift stays inside the alphabet
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_shift} < A6)
        else $error("running shift out of range");

    // a load word never raises a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_is_load && !r_out_valid) |=> !r_out_valid)
        else $error("load produced a result");

    // a stalled result blocks the next letter word
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && r_in_valid && w_has_result) |-> !o_in_ready)
        else $error("input taken while result stalled");

endmodule

### verif/tb_top.sv
module tb_top
    import rsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ALPHA          = 26;
    localparam int ROTORS         = 3;
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 7;
    localparam int PIPE_SLACK     = 6;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int REPORT_LIMIT   = 10;
    localparam int HOLD_LONG      = 400;

    // rotor select that no rotor answers to, and the operation code the block skips
    localparam logic [SELW-1:0] SEL_NONE  = 2'd3;
    localparam logic [OPW-1:0]  OP_UNUSED = 2'd3;

    logic            i_clk           = 1'b0;
    logic            i_rst_n         = 1'b0;
    logic            i_in_valid      = 1'b0;
    logic            o_in_ready;
    logic [OPW-1:0]  i_operation     = OP_UNUSED;
    logic [SELW-1:0] i_rotor_select  = '0;
    logic [LW-1:0]   i_entry_index   = '0;
    logic [LW-1:0]   i_letter        = '0;
    logic            i_message_start = 1'b0;
    logic            o_out_valid;
    logic            i_out_ready     = 1'b0;
    logic [LW-1:0]   o_result_letter;
    logic            i_cfg_we        = 1'b0;
    logic [LW-1:0]   i_cfg_data      = '0;

    // shadow of the cipher state
    logic [LW-1:0] rotor_tab [ROTORS][ALPHA];
    int            run_shift = 0;
    int            cfg_shift = 0;

    logic [LW-1:0] letters_due [$];
    int            fail_count     = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            hold_cycles    = 0;

    rotor_substitution_cipher dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_rotor_select  (i_rotor_select),
        .i_entry_index   (i_entry_index),
        .i_letter        (i_letter),
        .i_message_start (i_message_start),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_letter (o_result_letter),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int alpha_mod(input int v);
        return v % ALPHA;
    endfunction

    // advance the shadow state by one word, return 1 when a letter comes out
    function automatic bit cipher_step(input logic [OPW-1:0] op, input logic [SELW-1:0] sel,
                                       input logic [LW-1:0] idx, input logic [LW-1:0] ltr,
                                       input logic start, output logic [LW-1:0] res);
        int x;
        bit hit;
        res = '0;
        if (op == OP_LOAD) begin
            if (sel < ROTORS && idx < ALPHA) begin
                rotor_tab[sel][idx] = LW'(alpha_mod(int'(ltr)));
            end
            return 1'b0;
        end
        if (op != OP_ENCODE && op != OP_DECODE) begin
            return 1'b0;
        end
        if (start) begin
            run_shift = alpha_mod(cfg_shift);
        end
        x = alpha_mod(int'(ltr));
        if (op == OP_ENCODE) begin
            x = alpha_mod(x + run_shift);
            for (int r = 0; r < ROTORS; r++) begin
                x = int'(rotor_tab[r][x]);
            end
        end else begin
            // inverse rotors, last first, lowest matching position wins
            for (int r = ROTORS - 1; r >= 0; r--) begin
                hit = 1'b0;
                for (int j = 0; j < ALPHA; j++) begin
                    if (!hit && int'(rotor_tab[r][j]) == x) begin
                        x = j;
                        hit = 1'b1;
                    end
                end
            end
            x = alpha_mod(x + ALPHA - run_shift);
        end
        run_shift = alpha_mod(run_shift + 1);
        res = LW'(x);
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch (%s): expected %0d, actual %0d", what, want, got);
        end
    endtask

    // result check, then prediction of the accepted word, then config tracking
    always @(posedge i_clk) begin
        logic [LW-1:0] res;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (letters_due.size() == 0) begin
                    flag_mismatch("unexpected result word", -1, int'(o_result_letter));
                end else begin
                    res = letters_due.pop_front();
                    if (o_result_letter !== res) begin
                        flag_mismatch("result_letter", int'(res), int'(o_result_letter));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (cipher_step(i_operation, i_rotor_select, i_entry_index, i_letter,
                                i_message_start, res)) begin
                    letters_due.push_back(res);
                end
            end
            if (i_cfg_we) begin
                cfg_shift = int'(i_cfg_data);
            end
        end
    end

    // receiver: long hold-off when asked, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // send one word, with random idle cycles ahead of it
    task automatic send_word(input logic [OPW-1:0] op, input logic [SELW-1:0] sel,
                             input logic [LW-1:0] idx, input logic [LW-1:0] ltr,
                             input logic start);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_rotor_select  <= sel;
        i_entry_index   <= idx;
        i_letter        <= ltr;
        i_message_start <= start;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending and let every pending result come out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (letters_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    task automatic write_start_shift(input logic [LW-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [LW-1:0] pick_letter();
        if ($urandom_range(99) < 85) begin
            return LW'($urandom_range(ALPHA - 1));
        end
        return LW'($urandom_range(31, ALPHA));
    endfunction

    // fill every rotor entry, as a permutation or with arbitrary values
    task automatic load_rotors(input bit as_perm);
        int perm [ALPHA];
        int j;
        int t;
        logic [LW-1:0] val;
        for (int r = 0; r < ROTORS; r++) begin
            for (int i = 0; i < ALPHA; i++) begin
                perm[i] = i;
            end
            for (int i = ALPHA - 1; i > 0; i--) begin
                j       = $urandom_range(i);
                t       = perm[i];
                perm[i] = perm[j];
                perm[j] = t;
            end
            for (int i = 0; i < ALPHA; i++) begin
                if (!as_perm) begin
                    val = pick_letter();
                end else if (perm[i] < 32 - ALPHA && $urandom_range(1)) begin
                    // same entry written as an out-of-range value
                    val = LW'(perm[i] + ALPHA);
                end else begin
                    val = LW'(perm[i]);
                end
                send_word(OP_LOAD, SELW'(r), LW'(i), val, 1'($urandom_range(1)));
            end
        end
    endtask

    // ignored words: unused operation, load to a missing rotor or position
    task automatic send_noise();
        case ($urandom_range(2))
            0: begin
                send_word(OP_UNUSED, SELW'($urandom_range(3)), LW'($urandom_range(31)),
                          LW'($urandom_range(31)), 1'($urandom_range(1)));
            end
            1: begin
                send_word(OP_LOAD, SEL_NONE, LW'($urandom_range(31)),
                          LW'($urandom_range(31)), 1'($urandom_range(1)));
            end
            default: begin
                send_word(OP_LOAD, SELW'($urandom_range(3)), LW'($urandom_range(31, ALPHA)),
                          LW'($urandom_range(31)), 1'($urandom_range(1)));
            end
        endcase
    endtask

    // messages of random content, rotor rewrites and some noise
    task automatic run_traffic(input int n_words);
        int counted;
        int len;
        int pick;
        logic [OPW-1:0] msg_op;
        logic [OPW-1:0] op;
        counted = 0;
        while (counted < n_words) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_noise();
            end else if (pick < 18) begin
                send_word(OP_LOAD, SELW'($urandom_range(ROTORS - 1)),
                          LW'($urandom_range(ALPHA - 1)), pick_letter(),
                          1'($urandom_range(1)));
                counted++;
            end else begin
                len    = $urandom_range(30, 1);
                msg_op = $urandom_range(1) ? OP_ENCODE : OP_DECODE;
                for (int k = 0; k < len; k++) begin
                    op = ($urandom_range(99) < 80) ? msg_op
                       : ($urandom_range(1) ? OP_ENCODE : OP_DECODE);
                    send_word(op, SELW'($urandom_range(3)), LW'($urandom_range(31)),
                              pick_letter(), (k == 0) || ($urandom_range(99) < 3));
                    counted++;
                    if ($urandom_range(99) < 3) begin
                        send_noise();
                    end
                end
            end
        end
    endtask

    // ignored words while the rotors are still empty
    task automatic test_ignored_before_load();
        send_word(OP_UNUSED, SEL_NONE, LW'(31), LW'(31), 1'b1);
        send_word(OP_LOAD, SEL_NONE, LW'(0), LW'(0), 1'b0);
        send_word(OP_LOAD, SELW'(0), LW'(ALPHA), LW'(3), 1'b1);
        send_word(OP_LOAD, SELW'(2), LW'(31), LW'(31), 1'b0);
        send_word(OP_UNUSED, SELW'(0), LW'(0), LW'(0), 1'b0);
    endtask

    task automatic test_directed();
        write_start_shift(LW'(0));
        // field extremes on encode and decode
        send_word(OP_ENCODE, SELW'(0), LW'(0), LW'(0), 1'b1);
        send_word(OP_ENCODE, SEL_NONE, LW'(31), LW'(ALPHA - 1), 1'b0);
        send_word(OP_ENCODE, SELW'(0), LW'(0), LW'(ALPHA), 1'b0);
        send_word(OP_ENCODE, SELW'(0), LW'(0), LW'(31), 1'b0);
        send_word(OP_DECODE, SELW'(0), LW'(0), LW'(0), 1'b1);
        send_word(OP_DECODE, SELW'(0), LW'(0), LW'(ALPHA - 1), 1'b0);
        send_word(OP_DECODE, SEL_NONE, LW'(31), LW'(31), 1'b0);
        // ignored words inside a message leave the shift alone
        send_word(OP_UNUSED, SELW'(1), LW'(3), LW'(4), 1'b1);
        send_word(OP_ENCODE, SELW'(0), LW'(0), LW'(7), 1'b0);
        // message start on a load does nothing, value reduced
        send_word(OP_LOAD, SELW'(1), LW'(0), LW'(31), 1'b1);
        send_word(OP_ENCODE, SELW'(0), LW'(0), LW'(9), 1'b0);
        send_word(OP_DECODE, SELW'(0), LW'(0), LW'(5), 1'b0);
        send_word(OP_LOAD, SELW'(2), LW'(ALPHA - 1), LW'(0), 1'b0);
        send_word(OP_LOAD, SELW'(0), LW'(ALPHA - 1), LW'(ALPHA - 1), 1'b0);
        send_word(OP_LOAD, SEL_NONE, LW'(ALPHA - 1), LW'(1), 1'b0);
        send_word(OP_LOAD, SELW'(1), LW'(31), LW'(2), 1'b0);
        send_word(OP_ENCODE, SELW'(0), LW'(0), LW'(ALPHA - 1), 1'b1);
        send_word(OP_DECODE, SELW'(0), LW'(0), LW'(0), 1'b0);
        send_word(OP_DECODE, SELW'(0), LW'(0), LW'(ALPHA - 1), 1'b1);
        // one message of letters spread across the alphabet
        for (int k = 0; k < ALPHA + 2; k += 5) begin
            send_word(OP_ENCODE, SELW'(0), LW'(0), LW'(k % ALPHA), 1'b0);
        end
    endtask

    // start shift at its extremes and beyond the alphabet
    task automatic test_start_shift_sweep();
        logic [LW-1:0] shifts [5];
        shifts = '{LW'(0), LW'(ALPHA - 1), LW'(ALPHA), LW'(31), LW'($urandom_range(31))};
        for (int s = 0; s < 5; s++) begin
            write_start_shift(shifts[s]);
            run_traffic(25);
        end
    endtask

    // traffic under each idling pattern, rotors rewritten in between
    task automatic test_idle_phases();
        int send_pcts [4];
        int recv_pcts [4];
        send_pcts = '{0, 60, 0, 28};
        recv_pcts = '{0, 0, 60, 28};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            if (p != 0) begin
                load_rotors(p != 2);
            end
            write_start_shift(LW'($urandom_range(31)));
            run_traffic(200);
        end
    endtask

    // receiver blocked for a long stretch while words keep coming
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_idle();
        hold_cycles <= HOLD_LONG;
        for (int k = 0; k < 60; k++) begin
            send_word($urandom_range(1) ? OP_ENCODE : OP_DECODE, SELW'(0), LW'(0),
                      pick_letter(), k == 0);
        end
        wait_idle();
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        hold_cycles <= HOLD_LONG / 4;
        run_traffic(60);
        wait_idle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ignored_before_load();
        load_rotors(1'b1);
        test_directed();
        test_start_shift_sweep();
        test_idle_phases();
        test_backpressure();
        wait_idle();
        repeat (PIPE_SLACK) @(posedge i_clk);
        if (letters_due.size() != 0) begin
            flag_mismatch("result never came", int'(letters_due[0]), -1);
        end
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Some tests failed");
        $finish;
    end

endmodule
